@@ rtl/tgarle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared widths, header byte fields, register indexes and the staged item.
// ----------------------------------------------------------------------------
package tgarle_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int PIXEL_TOTAL_W  = 25;
	localparam int CFG_DATA_W     = PIXEL_TOTAL_W;
	localparam int CFG_INDEX_W    = 1;
	localparam int INDEX_W        = 24;
	localparam int VALUE_W        = 32;
	localparam int COUNT_W        = 8;

	// Packet header byte: bit 7 marks a run, the low seven bits hold length - 1.
	localparam int       RUN_FLAG_BIT = 7;
	localparam bit [6:0] LEN_MASK     = 7'h7f;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PIXEL_TOTAL = 1'b0,
		REG_FOUR_BYTE   = 1'b1
	} reg_idx_t;

	// One request held in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       image_start;
	} in_item_t;

endpackage : tgarle_pkg
`default_nettype wire

@@ rtl/tga_rle_pixel_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder
// Turns the compressed pixel byte stream of a TGA image into pixel results.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle while no result waits
// under stall, and gives at most one result for each byte: a result
// appears with the byte that completes a pixel. An accepted request sits
// in the input register, is decoded against the packet state and lands in
// the result register, from which its result is offered. The packet state
// update as each byte is taken is what sets the rate of one byte per
// cycle. A result that waits under stall holds the request behind it in
// the input register, and the input stalls while both registers are full;
// a result taken in the same cycle as a new request arrives keeps the
// stream moving without a gap. Header bytes with bit 7 set start a run
// (one pixel repeated up to 128 times); others start a raw packet of
// literal pixels. The pixel count stops at pixel_total (zero acts as one);
// the result that reaches it raises image_done, and a packet that would
// run past it is clipped and raises overrun_error. Bytes after that are
// dropped until a request with image_start set. Registers are to be
// written only while no request is in flight.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
	import tgarle_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   image_start,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [INDEX_W-1:0]          first_index,
	output logic [VALUE_W-1:0]          pixel_value,
	output logic [COUNT_W-1:0]          repeat_count,
	output logic                        image_done,
	output logic                        overrun_error
);

	in_item_t item_s1;
	logic     take;

	// Input register: holds one request, stalls only while it cannot move on.
	tgarle_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.image_start (image_start),
		.take        (take),
		.item_s1     (item_s1)
	);

	// Decode stage and result register.
	tgarle_decode #(
		.COUNT_BITS (COUNT_BITS)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_s1       (item_s1),
		.take          (take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.first_index   (first_index),
		.pixel_value   (pixel_value),
		.repeat_count  (repeat_count),
		.image_done    (image_done),
		.overrun_error (overrun_error)
	);

endmodule : tga_rle_pixel_decoder
`default_nettype wire

@@ rtl/tgarle_in_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE input register
// Holds one accepted byte request until the decode stage takes it.
// ----------------------------------------------------------------------------
module tgarle_in_reg
	import tgarle_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       image_start,
	input  wire logic       take,
	output in_item_t        item_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       accept;

	assign in_stall = valid_s1 & ~take;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_byte;
			start_s1 <= image_start;
		end
	end

	assign item_s1 = '{valid: valid_s1, data_byte: byte_s1, image_start: start_s1};

endmodule : tgarle_in_reg
`default_nettype wire

@@ rtl/tgarle_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE decode stage
// Packet state, pixel assembly, clipping against the total and the result
// register, plus the two configuration registers.
// ----------------------------------------------------------------------------
module tgarle_decode
	import tgarle_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire in_item_t              item_s1,
	output logic                       take,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [INDEX_W-1:0]         first_index,
	output logic [VALUE_W-1:0]         pixel_value,
	output logic [COUNT_W-1:0]         repeat_count,
	output logic                       image_done,
	output logic                       overrun_error
);

	localparam int CW = COUNT_BITS + 1;
	localparam int TW = (CW > PIXEL_TOTAL_W) ? CW : PIXEL_TOTAL_W;

	// Configuration
	logic [PIXEL_TOTAL_W-1:0] pixel_total_q;
	logic                     four_byte_q;

	// Packet and image state
	logic          expect_header_q;
	logic          is_run_q;
	logic [7:0]    left_q;
	logic [1:0]    bip_q;
	logic [23:0]   color_q;
	logic [CW-1:0] counter_q;
	logic          finished_q;

	// Result register
	logic               out_valid_q;
	logic [INDEX_W-1:0] index_q;
	logic [VALUE_W-1:0] value_q;
	logic [COUNT_W-1:0] count_q;
	logic               done_q;
	logic               overrun_q;

	logic          out_free;
	logic [TW-1:0] tot_wide;
	logic [TW-1:0] cap_wide;
	logic [CW-1:0] total;

	// Next-state view
	logic          cur_eh, cur_run, cur_fin;
	logic [7:0]    cur_left;
	logic [1:0]    cur_bip;
	logic [23:0]   cur_color;
	logic [CW-1:0] cur_cnt;
	logic          nxt_eh, nxt_run, nxt_fin;
	logic [7:0]    nxt_left;
	logic [1:0]    nxt_bip;
	logic [23:0]   nxt_color;
	logic [CW-1:0] nxt_cnt;
	logic          emit;
	logic [VALUE_W-1:0] res_value;
	logic [COUNT_W-1:0] res_count;
	logic          res_done;
	logic          res_overrun;
	logic [CW-1:0] remaining;
	logic [1:0]    last_pos;
	logic [7:0]    b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total_q <= PIXEL_TOTAL_W'(1);
			four_byte_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PIXEL_TOTAL: pixel_total_q <= cfg_data;
				REG_FOUR_BYTE:   four_byte_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A total of zero acts as one; above 1 << COUNT_BITS it saturates to that value.
	always_comb begin
		cap_wide = TW'(1) << COUNT_BITS;
		tot_wide = TW'(pixel_total_q);
		if (tot_wide == '0) begin
			tot_wide = TW'(1);
		end else if (tot_wide > cap_wide) begin
			tot_wide = cap_wide;
		end
		total = CW'(tot_wide);
	end

	assign out_free = ~out_valid_q | ~out_stall;
	assign take     = item_s1.valid & out_free;
	assign b        = item_s1.data_byte;
	assign last_pos = four_byte_q ? 2'd3 : 2'd2;

	always_comb begin
		// image_start clears the image state before the byte is looked at
		if (item_s1.image_start) begin
			cur_eh    = 1'b1;
			cur_run   = 1'b0;
			cur_left  = '0;
			cur_bip   = '0;
			cur_color = '0;
			cur_cnt   = '0;
			cur_fin   = 1'b0;
		end else begin
			cur_eh    = expect_header_q;
			cur_run   = is_run_q;
			cur_left  = left_q;
			cur_bip   = bip_q;
			cur_color = color_q;
			cur_cnt   = counter_q;
			cur_fin   = finished_q;
		end

		nxt_eh      = cur_eh;
		nxt_run     = cur_run;
		nxt_left    = cur_left;
		nxt_bip     = cur_bip;
		nxt_color   = cur_color;
		nxt_cnt     = cur_cnt;
		nxt_fin     = cur_fin;
		emit        = 1'b0;
		res_value   = '0;
		res_count   = '0;
		res_done    = 1'b0;
		res_overrun = 1'b0;
		remaining   = total - cur_cnt;

		if (cur_fin) begin
			// bytes after done are dropped
		end else if (cur_cnt >= total) begin
			// total was lowered below the count already reached
			nxt_fin = 1'b1;
		end else if (cur_eh) begin
			nxt_run   = b[RUN_FLAG_BIT];
			nxt_left  = {1'b0, b[6:0] & LEN_MASK} + 8'd1;
			nxt_eh    = 1'b0;
			nxt_bip   = '0;
			nxt_color = '0;
		end else if (cur_bip < last_pos) begin
			case (cur_bip)
				2'd0:    nxt_color = cur_color | {16'd0, b};
				2'd1:    nxt_color = cur_color | {8'd0, b, 8'd0};
				default: nxt_color = cur_color | {b, 16'd0};
			endcase
			nxt_bip = cur_bip + 2'd1;
		end else begin
			emit      = 1'b1;
			res_value = {8'd0, cur_color} | (VALUE_W'(b) << {cur_bip, 3'b000});
			if (cur_run) begin
				if (CW'(cur_left) > remaining) begin
					res_count   = remaining[COUNT_W-1:0];
					res_overrun = 1'b1;
				end else begin
					res_count = cur_left;
				end
				nxt_left = '0;
			end else begin
				res_count = COUNT_W'(1);
				nxt_left  = cur_left - 8'd1;
				res_overrun = (remaining == CW'(1)) && (nxt_left != '0);
			end
			nxt_cnt   = cur_cnt + CW'(res_count);
			res_done  = (nxt_cnt == total);
			nxt_bip   = '0;
			nxt_color = '0;
			if (nxt_left == '0) begin
				nxt_eh = 1'b1;
			end
			if (res_done) begin
				nxt_fin = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			is_run_q        <= 1'b0;
			left_q          <= '0;
			bip_q           <= '0;
			color_q         <= '0;
			counter_q       <= '0;
			finished_q      <= 1'b0;
		end else if (take) begin
			expect_header_q <= nxt_eh;
			is_run_q        <= nxt_run;
			left_q          <= nxt_left;
			bip_q           <= nxt_bip;
			color_q         <= nxt_color;
			counter_q       <= nxt_cnt;
			finished_q      <= nxt_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			index_q   <= INDEX_W'(cur_cnt);
			value_q   <= res_value;
			count_q   <= res_count;
			done_q    <= res_done;
			overrun_q <= res_overrun;
		end
	end

	assign out_valid     = out_valid_q;
	assign first_index   = index_q;
	assign pixel_value   = value_q;
	assign repeat_count  = count_q;
	assign image_done    = done_q;
	assign overrun_error = overrun_q;

endmodule : tgarle_decode
`default_nettype wire

@@ rtl/tgarle_props.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE decoder port checks
// Watches the result port of the decoder over time.
// ----------------------------------------------------------------------------
module tgarle_props
	import tgarle_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [INDEX_W-1:0] first_index,
	input wire logic [VALUE_W-1:0] pixel_value,
	input wire logic [COUNT_W-1:0] repeat_count,
	input wire logic               image_done,
	input wire logic               overrun_error
);

	// A stalled result stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(first_index)
			&& $stable(pixel_value) && $stable(repeat_count)
			&& $stable(image_done) && $stable(overrun_error))
		else $error("stalled result changed");

	// Every result fills between one and a full run of pixels.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (repeat_count != '0) && (repeat_count <= COUNT_W'(128)))
		else $error("repeat count out of range");

	// Clipping only happens on the result that reaches the total.
	a_overrun_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun_error |-> image_done)
		else $error("overrun flagged without image done");

endmodule : tgarle_props

bind tga_rle_pixel_decoder tgarle_props u_props (.*);
`default_nettype wire
